@@ src/sre_pkg.sv @@
// ----------------------------------------------------------------------------
// Sound register log encoder package
// Shared types, command codes and register indices of the log encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sre_pkg;

  localparam logic [3:0] OP_TICK     = 4'd0;
  localparam logic [3:0] OP_APU_PRI  = 4'd1;
  localparam logic [3:0] OP_APU_SEC  = 4'd2;
  localparam logic [3:0] OP_DISK     = 4'd3;
  localparam logic [3:0] OP_PULSE    = 4'd4;
  localparam logic [3:0] OP_WAVE     = 4'd5;
  localparam logic [3:0] OP_SAW      = 4'd6;
  localparam logic [3:0] OP_FM_EXP   = 4'd7;
  localparam logic [3:0] OP_PSG      = 4'd8;
  localparam logic [3:0] OP_FM_CHIP  = 4'd9;
  localparam logic [3:0] OP_FINISH   = 4'd10;

  localparam logic [1:0] CFG_IDX_NUM = 2'd0;
  localparam logic [1:0] CFG_IDX_DEN = 2'd1;

  localparam logic [15:0] NUM_RESET = 16'd1617;
  localparam logic [16:0] DEN_RESET = 17'd66250;

  localparam logic [7:0] CMD_WAIT16  = 8'h61;
  localparam logic [7:0] CMD_WAIT60  = 8'h62;
  localparam logic [7:0] CMD_WAIT50  = 8'h63;
  localparam logic [7:0] CMD_WAITN   = 8'h70;
  localparam logic [7:0] CMD_WAITMAX = 8'h7F;
  localparam logic [7:0] CMD_END     = 8'h66;
  localparam logic [7:0] CMD_APU     = 8'hB4;
  localparam logic [7:0] CMD_DAC     = 8'h32;
  localparam logic [7:0] CMD_WAVE    = 8'h43;
  localparam logic [7:0] CMD_SAW     = 8'h42;
  localparam logic [7:0] CMD_OPLL    = 8'h51;
  localparam logic [7:0] CMD_PSG     = 8'hA0;

  localparam logic [15:0] FRAME_NTSC   = 16'd735;
  localparam logic [15:0] FRAME_PAL    = 16'd882;
  localparam logic [15:0] FRAME_NTSC2  = 16'd1470;
  localparam logic [15:0] FRAME_MIXED  = 16'd1617;
  localparam logic [15:0] FRAME_PAL2   = 16'd1764;
  localparam logic [15:0] PENDING_SAT  = 16'hFFFF;

  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] b;
  } sre_bytes_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SUB,
    ST_INC,
    ST_SAT,
    ST_WAIT,
    ST_CMD,
    ST_EMIT
  } sre_state_e;

endpackage

`default_nettype wire

@@ src/sre_encode.sv @@
// ----------------------------------------------------------------------------
// Sound register log encoder command formatter
// Encodes a pending sample count as wait bytes, and a register write or a finish
// as a remapped command or the end command.
// ----------------------------------------------------------------------------
`default_nettype none

module sre_encode (
  input  logic [3:0]          op_i,
  input  logic [15:0]         addr_i,
  input  logic [7:0]          data_i,
  input  logic [15:0]         pending_i,
  output sre_pkg::sre_bytes_t wait_o,
  output sre_pkg::sre_bytes_t cmd_o
);
  import sre_pkg::*;

  logic [7:0]  idx;
  logic [15:0] bus_off;

  assign idx     = addr_i[7:0];
  assign bus_off = addr_i - 16'h1000;

  always_comb begin
    wait_o = '0;
    if (pending_i == 16'd0) begin
      wait_o.n = 2'd0;
    end else if (pending_i <= 16'd16) begin
      wait_o.n    = 2'd1;
      wait_o.b[0] = CMD_WAITN + pending_i[7:0] - 8'd1;
    end else if (pending_i <= 16'd32) begin
      wait_o.n    = 2'd2;
      wait_o.b[0] = CMD_WAITMAX;
      wait_o.b[1] = CMD_WAITN + pending_i[7:0] - 8'd17;
    end else if (pending_i == FRAME_NTSC) begin
      wait_o.n    = 2'd1;
      wait_o.b[0] = CMD_WAIT60;
    end else if (pending_i == FRAME_PAL) begin
      wait_o.n    = 2'd1;
      wait_o.b[0] = CMD_WAIT50;
    end else if (pending_i == FRAME_NTSC2) begin
      wait_o.n    = 2'd2;
      wait_o.b[0] = CMD_WAIT60;
      wait_o.b[1] = CMD_WAIT60;
    end else if (pending_i == FRAME_MIXED) begin
      wait_o.n    = 2'd2;
      wait_o.b[0] = CMD_WAIT60;
      wait_o.b[1] = CMD_WAIT50;
    end else if (pending_i == FRAME_PAL2) begin
      wait_o.n    = 2'd2;
      wait_o.b[0] = CMD_WAIT50;
      wait_o.b[1] = CMD_WAIT50;
    end else begin
      wait_o.n    = 2'd3;
      wait_o.b[0] = CMD_WAIT16;
      wait_o.b[1] = pending_i[7:0];
      wait_o.b[2] = pending_i[15:8];
    end
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.n    = 2'd3;
    cmd_o.b[1] = idx;
    cmd_o.b[2] = data_i;
    case (op_i)
      OP_APU_PRI: begin
        cmd_o.b[0] = CMD_APU;
      end
      OP_APU_SEC: begin
        cmd_o.b[0] = CMD_APU;
        cmd_o.b[1] = idx | 8'h80;
      end
      OP_DISK: begin
        cmd_o.b[0] = CMD_APU;
        if (idx >= 8'h80 && idx <= 8'h9E) begin
          cmd_o.b[1] = idx - 8'h60;
        end else if (idx == 8'h23) begin
          cmd_o.b[1] = 8'h3F;
        end
      end
      OP_PULSE: begin
        if (idx == 8'h10) begin
          cmd_o.n    = 2'd2;
          cmd_o.b[0] = CMD_DAC;
          cmd_o.b[1] = data_i;
          cmd_o.b[2] = 8'h00;
        end else begin
          cmd_o.b[0] = CMD_APU;
          cmd_o.b[1] = idx | 8'h80;
        end
      end
      OP_WAVE: begin
        cmd_o.b[0] = CMD_WAVE;
      end
      OP_SAW: begin
        cmd_o.b[0] = CMD_SAW;
        cmd_o.b[1] = {4'b0000, bus_off[13:12], addr_i[1:0]};
      end
      OP_FM_EXP: begin
        cmd_o.b[0] = CMD_OPLL;
      end
      OP_PSG: begin
        cmd_o.b[0] = CMD_PSG;
      end
      OP_FM_CHIP: begin
        cmd_o.b[0] = CMD_OPLL;
      end
      OP_FINISH: begin
        cmd_o.n    = 2'd1;
        cmd_o.b[0] = CMD_END;
        cmd_o.b[1] = 8'h00;
        cmd_o.b[2] = 8'h00;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/sound_register_log_encoder_top.sv @@
// ----------------------------------------------------------------------------
// Sound register log encoder
// Turns emulator ticks and sound register writes into log command bytes.
// ----------------------------------------------------------------------------
// A tick passes through some of the add, subtract and increment states on the
// shared adder and then a saturation check before input is ready again; a tick
// that saturates the pending count adds a flush state and three bytes. A write or
// finish takes a flush state and a formatting state, then one output byte per
// cycle while the output is ready, one to six bytes in all. Reset is asynchronous,
// active low, and restores rate 1617/66250.
`default_nettype none

module sound_register_log_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // reg_address [15:0], write_data [23:16]
  input  logic [23:0] s_axis_tdata,
  // opcode [3:0]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte [7:0], chips_used [16:8], sample_total [48:17], zero [55:49]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import sre_pkg::*;

  sre_state_e state_q, state_d;

  logic [15:0] num_q, num_d;
  logic [16:0] den_q, den_d;
  logic [16:0] acc_q, acc_d;
  logic [15:0] pend_q, pend_d;
  logic [31:0] total_q, total_d;
  logic [8:0]  kinds_q, kinds_d;
  logic [17:0] tmp_q, tmp_d;
  logic [3:0]  op_q, op_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  data_q, data_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [2:0]  rd_q, rd_d;
  logic [5:0][7:0] obuf_q, obuf_d;

  logic [31:0] add_a, add_b;
  logic        add_cin;
  logic [32:0] add_sum;

  logic        out_last;
  sre_bytes_t  wait_b, cmd_b;

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};

  sre_encode u_encode (
    .op_i      (op_q),
    .addr_i    (addr_q),
    .data_i    (data_q),
    .pending_i (pend_q),
    .wait_o    (wait_b),
    .cmd_o     (cmd_b)
  );

  assign cfg_ready_o   = 1'b1;
  assign out_last      = (rd_q == (cnt_q - 3'd1));
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {7'd0, total_q, kinds_q, obuf_q[rd_q]};

  always_comb begin
    state_d       = state_q;
    num_d         = num_q;
    den_d         = den_q;
    acc_d         = acc_q;
    pend_d        = pend_q;
    total_d       = total_q;
    kinds_d       = kinds_q;
    tmp_d         = tmp_q;
    op_d          = op_q;
    addr_d        = addr_q;
    data_d        = data_q;
    cnt_d         = cnt_q;
    rd_d          = rd_q;
    obuf_d        = obuf_q;
    add_a         = 32'd0;
    add_b         = 32'd0;
    add_cin       = 1'b0;
    s_axis_tready = 1'b0;

    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_IDX_NUM) begin
        num_d = cfg_data_i[15:0];
      end else if (cfg_index_i == CFG_IDX_DEN) begin
        den_d = cfg_data_i;
      end
    end

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d   = s_axis_tuser;
          addr_d = s_axis_tdata[15:0];
          data_d = s_axis_tdata[23:16];
          cnt_d  = 3'd0;
          rd_d   = 3'd0;
          if (s_axis_tuser > OP_FINISH) begin
            state_d = ST_IDLE;
          end else if (s_axis_tuser == OP_TICK) begin
            if (num_q == 16'd0) begin
              state_d = ST_SAT;
            end else if (den_q <= {1'b0, num_q}) begin
              acc_d   = 17'd0;
              state_d = ST_INC;
            end else begin
              state_d = ST_ADD;
            end
          end else begin
            state_d = ST_WAIT;
          end
        end
      end
      ST_ADD: begin
        add_a   = {15'd0, acc_q};
        add_b   = {16'd0, num_q};
        tmp_d   = add_sum[17:0];
        state_d = ST_SUB;
      end
      ST_SUB: begin
        add_a   = {14'd0, tmp_q};
        add_b   = ~{15'd0, den_q};
        add_cin = 1'b1;
        if (add_sum[32]) begin
          acc_d   = add_sum[16:0];
          state_d = ST_INC;
        end else begin
          acc_d   = tmp_q[16:0];
          state_d = ST_SAT;
        end
      end
      ST_INC: begin
        add_a   = {16'd0, pend_q};
        add_cin = 1'b1;
        pend_d  = add_sum[15:0];
        state_d = ST_SAT;
      end
      ST_SAT: begin
        state_d = (pend_q == PENDING_SAT) ? ST_WAIT : ST_IDLE;
      end
      ST_WAIT: begin
        add_a   = total_q;
        add_b   = {16'd0, pend_q};
        total_d = add_sum[31:0];
        pend_d  = 16'd0;
        for (int i = 0; i < 3; i++) begin
          if (i < int'(wait_b.n)) begin
            obuf_d[3'(i)] = wait_b.b[i];
          end
        end
        cnt_d   = {1'b0, wait_b.n};
        state_d = (op_q == OP_TICK) ? ST_EMIT : ST_CMD;
      end
      ST_CMD: begin
        for (int i = 0; i < 3; i++) begin
          if (i < int'(cmd_b.n)) begin
            obuf_d[3'(cnt_q + 3'(i))] = cmd_b.b[i];
          end
        end
        cnt_d = cnt_q + {1'b0, cmd_b.n};
        if (op_q != OP_FINISH) begin
          kinds_d = kinds_q | (9'd1 << (op_q - 4'd1));
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (m_axis_tready) begin
          rd_d = rd_q + 3'd1;
          if (out_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      num_q   <= NUM_RESET;
      den_q   <= DEN_RESET;
      acc_q   <= 17'd0;
      pend_q  <= 16'd0;
      total_q <= 32'd0;
      kinds_q <= 9'd0;
      cnt_q   <= 3'd0;
      rd_q    <= 3'd0;
    end else begin
      state_q <= state_d;
      num_q   <= num_d;
      den_q   <= den_d;
      acc_q   <= acc_d;
      pend_q  <= pend_d;
      total_q <= total_d;
      kinds_q <= kinds_d;
      cnt_q   <= cnt_d;
      rd_q    <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q  <= tmp_d;
    op_q   <= op_d;
    addr_q <= addr_d;
    data_q <= data_d;
    obuf_q <= obuf_d;
  end

endmodule

`default_nettype wire

@@ src/sre_checker.sv @@
// ----------------------------------------------------------------------------
// Sound register log encoder checker
// Port-level checks on the sequencing of input and output transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module sre_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  input  wire        s_axis_tready,
  input  wire [3:0]  s_axis_tuser,
  input  wire        m_axis_tvalid,
  input  wire        m_axis_tready,
  input  wire [55:0] m_axis_tdata,
  input  wire        m_axis_tlast
);
  import sre_pkg::*;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("Input accepted while output bytes are pending.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser <= OP_FINISH)) |=> !s_axis_tready)
    else $error("Input ready did not drop after an input transfer.");

  a_status_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && $stable(m_axis_tdata[48:8])))
    else $error("Status fields changed within one item's output bytes.");

  a_end_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("Output stayed valid after the final byte of an item.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("Stalled output transfer changed.");

endmodule

bind sound_register_log_encoder_top sre_checker u_sre_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Sound register log encoder testbench
// Drives ticks, register writes and finish commands into the encoder under
// several sample rates, predicts every command byte with its flags, mask and
// sample total, and compares each byte that leaves the block against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import sre_pkg::*;

  typedef struct packed {
    logic [7:0]  cmd_byte;
    logic        last;
    logic [8:0]  chips;
    logic [31:0] total;
  } log_byte_t;

  class log_byte_predictor;
    logic [15:0] rate_num;
    logic [16:0] rate_den;
    logic [16:0] frac_acc;
    logic [15:0] pend_samples;
    logic [31:0] sample_sum;
    logic [8:0]  kind_mask;
    logic [7:0]  item_bytes[$];
    log_byte_t   due_bytes[$];
    int          errors;

    function new();
      rate_num     = NUM_RESET;
      rate_den     = DEN_RESET;
      frac_acc     = '0;
      pend_samples = '0;
      sample_sum   = '0;
      kind_mask    = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [16:0] value);
      if (idx == CFG_IDX_NUM) begin
        rate_num = value[15:0];
      end else if (idx == CFG_IDX_DEN) begin
        rate_den = value;
      end
    endfunction

    function void add_byte(logic [7:0] v);
      item_bytes.insert(item_bytes.size(), v);
    endfunction

    function void triple(logic [7:0] cmd, logic [7:0] a, logic [7:0] d);
      add_byte(cmd);
      add_byte(a);
      add_byte(d);
    endfunction

    // Turns the pending sample count into wait commands and clears it.
    function void flush_wait();
      logic [15:0] p;
      p = pend_samples;
      pend_samples = '0;
      if (p == 0) begin
        return;
      end
      if (p <= 16) begin
        add_byte(CMD_WAITN + p[7:0] - 8'd1);
      end else if (p <= 32) begin
        add_byte(CMD_WAITMAX);
        add_byte(CMD_WAITN + p[7:0] - 8'd17);
      end else if (p == FRAME_NTSC) begin
        add_byte(CMD_WAIT60);
      end else if (p == FRAME_PAL) begin
        add_byte(CMD_WAIT50);
      end else if (p == FRAME_NTSC2) begin
        add_byte(CMD_WAIT60);
        add_byte(CMD_WAIT60);
      end else if (p == FRAME_MIXED) begin
        add_byte(CMD_WAIT60);
        add_byte(CMD_WAIT50);
      end else if (p == FRAME_PAL2) begin
        add_byte(CMD_WAIT50);
        add_byte(CMD_WAIT50);
      end else begin
        add_byte(CMD_WAIT16);
        add_byte(p[7:0]);
        add_byte(p[15:8]);
      end
      sample_sum = sample_sum + p;
    endfunction

    function void note_item(logic [3:0] op, logic [15:0] addr, logic [7:0] data);
      logic [17:0] s;
      logic [7:0]  idx;
      logic [15:0] shifted;
      log_byte_t   b;
      item_bytes.delete();
      idx = addr[7:0];
      if (op > OP_FINISH) begin
        return;
      end
      if (op == OP_TICK) begin
        if (rate_num != 0) begin
          if (rate_den <= {1'b0, rate_num}) begin
            frac_acc = '0;
            pend_samples = pend_samples + 16'd1;
          end else begin
            s = frac_acc + rate_num;
            if (s >= rate_den) begin
              s = s - rate_den;
              pend_samples = pend_samples + 16'd1;
            end
            frac_acc = s[16:0];
          end
        end
        if (pend_samples == PENDING_SAT) begin
          flush_wait();
        end
      end else if (op == OP_FINISH) begin
        flush_wait();
        add_byte(CMD_END);
      end else begin
        flush_wait();
        kind_mask[op - 4'd1] = 1'b1;
        case (op)
          OP_APU_PRI: triple(CMD_APU, idx, data);
          OP_APU_SEC: triple(CMD_APU, idx | 8'h80, data);
          OP_DISK: begin
            if (idx >= 8'h80 && idx <= 8'h9E) begin
              idx = idx - 8'h60;
            end else if (idx == 8'h23) begin
              idx = 8'h3F;
            end
            triple(CMD_APU, idx, data);
          end
          OP_PULSE: begin
            if (idx == 8'h10) begin
              add_byte(CMD_DAC);
              add_byte(data);
            end else begin
              triple(CMD_APU, idx | 8'h80, data);
            end
          end
          OP_WAVE: triple(CMD_WAVE, idx, data);
          OP_SAW: begin
            shifted = addr - 16'h1000;
            triple(CMD_SAW, {4'd0, shifted[13:12], addr[1:0]}, data);
          end
          OP_FM_EXP: triple(CMD_OPLL, idx, data);
          OP_PSG: triple(CMD_PSG, idx, data);
          default: triple(CMD_OPLL, idx, data);
        endcase
      end
      foreach (item_bytes[k]) begin
        b.cmd_byte = item_bytes[k];
        b.last     = (k == item_bytes.size() - 1);
        b.chips    = kind_mask;
        b.total    = sample_sum;
        due_bytes.insert(due_bytes.size(), b);
      end
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch in %s: got %0h, expected %0h", field, got, want);
    endtask

    task check_byte(logic [55:0] tdata, logic tlast);
      log_byte_t want;
      if (due_bytes.size() == 0) begin
        report("unexpected byte", tdata[7:0], 0);
        return;
      end
      want = due_bytes.pop_front();
      if (tdata[7:0] !== want.cmd_byte) report("out_byte", tdata[7:0], want.cmd_byte);
      if (tlast !== want.last) report("last", tlast, want.last);
      if (tdata[16:8] !== want.chips) report("chips_used", tdata[16:8], want.chips);
      if (tdata[48:17] !== want.total) report("sample_total", tdata[48:17], want.total);
      if (tdata[55:49] !== 7'd0) report("padding", tdata[55:49], 0);
    endtask
  endclass

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int RATE_SETS   = 9;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [16:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [3:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  log_byte_predictor log_pred;
  int          cycles = 0;
  int          burst_left = 0;
  int          items_sent = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  int          wait_lens[5] = '{1, 16, 17, 32, 33};
  logic [16:0] num_set[RATE_SETS] = '{17'd1, 17'h1FFFF, 17'd65535, 17'd0, 17'd7,
                                      17'd7, 17'd1617, 17'd0, 17'd40000};
  logic [16:0] den_set[RATE_SETS] = '{17'h1FFFF, 17'h1FFFF, 17'd2, 17'd66250, 17'd0,
                                      17'd1, 17'd66250, 17'd0, 17'd40000};

  sound_register_log_encoder_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        log_pred.note_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[23:16]);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        log_pred.set_reg(cfg_index_i, cfg_data_i);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        log_pred.check_byte(m_axis_tdata, m_axis_tlast);
      end
    end
  end

  // The receiver follows a rotating stall pattern that is now and then
  // replaced, sometimes by one that never stalls.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pat = 16'hFFFF;
        1: stall_pat = 16'($urandom);
        2: stall_pat = 16'($urandom | $urandom);
        default: stall_pat = 16'($urandom & $urandom);
      endcase
    end
    m_axis_tready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[15:1]};
  end

  task automatic send_item(input logic [3:0] op, input logic [15:0] addr,
                           input logic [7:0] data, input bit with_gaps);
    int gap;
    if (with_gaps && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {data, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op <= OP_FINISH) begin
      items_sent++;
    end
    @(negedge clk_i);
  endtask

  task automatic tick_run(input int n);
    repeat (n) send_item(OP_TICK, 16'($urandom), 8'($urandom), 1'b0);
  endtask

  // Holds the sender back until every predicted byte has left the block,
  // then allows for a tick that may still be in flight.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (log_pred.due_bytes.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic set_rate(input logic [16:0] num, input logic [16:0] den);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_IDX_NUM;
    cfg_data_i  <= num;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_index_i <= CFG_IDX_DEN;
    cfg_data_i  <= den;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_step();
    int          r;
    int          n;
    logic [3:0]  op;
    logic [15:0] addr;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      op = 4'($urandom_range(OP_FINISH + 1, 15));
      send_item(op, 16'($urandom), 8'($urandom), 1'b1);
      return;
    end
    if (r < 55) begin
      n = $urandom_range(1, 8);
      repeat (n) send_item(OP_TICK, 16'($urandom), 8'($urandom), 1'b1);
    end
    op   = 4'($urandom_range(OP_APU_PRI, OP_FINISH));
    addr = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 6))
        0: addr[7:0] = 8'h10;
        1: addr[7:0] = 8'h23;
        2: addr[7:0] = 8'h80;
        3: addr[7:0] = 8'h9E;
        4: addr[7:0] = 8'h9F;
        5: addr = 16'h1000;
        default: addr[7:0] = 8'h7F;
      endcase
    end
    send_item(op, addr, 8'($urandom), 1'b1);
  endtask

  initial begin
    int start;
    log_pred      = new();
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_IDX_NUM;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    m_axis_tready = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_item(OP_APU_PRI, 16'h0000, 8'h00, 1'b1);
    send_item(OP_APU_PRI, 16'hFFFF, 8'hFF, 1'b1);
    send_item(OP_APU_SEC, 16'h0015, 8'h5A, 1'b1);
    send_item(OP_DISK,    16'h0080, 8'h11, 1'b1);
    send_item(OP_DISK,    16'h009E, 8'h22, 1'b1);
    send_item(OP_DISK,    16'h0023, 8'h33, 1'b1);
    send_item(OP_DISK,    16'h009F, 8'h44, 1'b1);
    send_item(OP_DISK,    16'h007F, 8'h55, 1'b1);
    send_item(OP_PULSE,   16'h0010, 8'hA5, 1'b1);
    send_item(OP_PULSE,   16'hA510, 8'h5A, 1'b1);
    send_item(OP_PULSE,   16'h0011, 8'h66, 1'b1);
    send_item(OP_WAVE,    16'h0040, 8'h77, 1'b1);
    send_item(OP_SAW,     16'h1000, 8'h88, 1'b1);
    send_item(OP_SAW,     16'h0FFF, 8'h99, 1'b1);
    send_item(OP_SAW,     16'h9003, 8'hAA, 1'b1);
    send_item(OP_FM_EXP,  16'h0030, 8'hBB, 1'b1);
    send_item(OP_PSG,     16'h0007, 8'hCC, 1'b1);
    send_item(OP_FM_CHIP, 16'h000E, 8'hDD, 1'b1);
    send_item(4'd11,      16'h1234, 8'hEE, 1'b1);
    send_item(4'd15,      16'hFFFF, 8'hFF, 1'b1);
    send_item(OP_FINISH,  16'h0000, 8'h00, 1'b1);
    tick_run(12);
    send_item(OP_APU_PRI, 16'h0001, 8'h01, 1'b1);

    // One sample per tick, so each run of ticks becomes a wait of that length.
    settle();
    set_rate(17'd100, 17'd3);
    foreach (wait_lens[i]) begin
      tick_run(wait_lens[i]);
      send_item((i % 2) ? OP_FINISH : OP_PSG, 16'h0007, 8'h3C, 1'b0);
    end
    tick_run(5);
    send_item(OP_FINISH, 16'h0000, 8'h00, 1'b0);

    num_set[7] = 17'($urandom_range(1, 65535));
    den_set[7] = 17'($urandom_range(2, 131071));
    for (int p = 0; p < RATE_SETS; p++) begin
      settle();
      set_rate(num_set[p], den_set[p]);
      start = items_sent;
      while (items_sent - start < 6) random_step();
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (log_pred.errors == 0 && log_pred.due_bytes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
src/sre_pkg.sv
src/sre_encode.sv
src/sound_register_log_encoder_top.sv
src/sre_checker.sv
bench/tb.sv
